// ----- rtl/sacl_pkg.sv -----
// Package for the set-associative LFU cache.
// Holds the sizes, the op and state codes and the control structs.
// No dependencies.
package sacl_pkg;

  localparam int MAX_SET_BITS    = 4;
  localparam int MAX_OFFSET_BITS = 4;
  localparam int MAX_WAYS        = 4;
  localparam int ADDR_BITS       = 12;

  localparam int WAY_BITS   = $clog2(MAX_WAYS);
  localparam int LINE_BITS  = MAX_SET_BITS + WAY_BITS;
  localparam int NUM_LINES  = 1 << LINE_BITS;
  localparam int BYTE_BITS  = LINE_BITS + MAX_OFFSET_BITS;
  localparam int NUM_BYTES  = 1 << BYTE_BITS;
  localparam int MEM_SIZE   = 1 << ADDR_BITS;
  localparam int FREQ_BITS  = 8;
  localparam int META_BITS  = ADDR_BITS + FREQ_BITS;
  localparam int CNT_BITS   = MAX_OFFSET_BITS + 1;
  localparam int CFG_BITS   = 3;
  localparam int IDX_BITS   = 2;

  typedef enum logic [1:0] {
    OP_READ    = 2'd0,
    OP_WRITE   = 2'd1,
    OP_PRELOAD = 2'd2,
    OP_NONE    = 2'd3
  } op_t;

  typedef enum logic [1:0] {
    REG_SET_BITS    = 2'd0,
    REG_OFFSET_BITS = 2'd1,
    REG_WAYS        = 2'd2,
    REG_UNUSED      = 2'd3
  } reg_idx_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_DISPATCH,
    ST_SCAN_RD,
    ST_SCAN_CHK,
    ST_HIT,
    ST_FILL,
    ST_META_FILL,
    ST_FINAL,
    ST_RD_WAIT,
    ST_DONE
  } state_t;

  typedef struct packed {
    logic accept;
    logic scan_chk;
    logic hit_upd;
    logic fill_step;
    logic meta_fill;
    logic final_acc;
    logic capture;
    logic load_out;
  } cmd_t;

  typedef struct packed {
    op_t  op;
    logic tag_match;
    logic last_way;
    logic fill_done;
    logic out_free;
  } status_t;

endpackage

// ----- rtl/set_assoc_cache_lfu.sv -----
// Top level of the set-associative LFU cache with internal backing memory.
// Depends on sacl_pkg, sacl_ctrl and sacl_dp.
//
// Usage: items arrive on the s_ stream (op, address, write_data) and each
// item gives exactly one result item on the m_ stream (read_data, hit).
// Op 0 reads a byte, op 1 writes a byte (write-through on a hit, allocate
// on a miss), op 2 preloads a backing memory byte, op 3 does nothing.
// Registers are written on the cfg port (index 0 set bits, 1 offset bits,
// 2 ways in use) while the block is idle; cfg_ready is always high.
// One item is handled at a time. The way walk reads the tag/frequency RAM
// once per way in use, in a read state and a check state, and stops at a hit;
// on a miss the block bytes are then fetched one a cycle over the backing
// memory port. Preload and the idle op skip the way walk.
// The result sits in an output register; a new item is taken while it
// waits, and the block stalls only when its next result is ready while the
// previous one is still not taken. Reset clears the line valid bits and
// the registers at once; no clearing pass is needed.
module set_assoc_cache_lfu
  import sacl_pkg::*;
(
  input  logic                clk,
  input  logic                rst,
  input  logic                s_tvalid,
  output logic                s_tready,
  input  logic [23:0]         s_tdata,   // op[1:0], address[13:2], write_data[21:14]
  output logic                m_tvalid,
  input  logic                m_tready,
  output logic [15:0]         m_tdata,   // read_data[7:0], hit[8]
  input  logic                cfg_valid,
  output logic                cfg_ready,
  input  logic [IDX_BITS-1:0] cfg_index,
  input  logic [CFG_BITS-1:0] cfg_data
);

  cmd_t       cmd;
  status_t    st;
  logic [7:0] read_data;
  logic       hit;

  assign cfg_ready = 1'b1;
  assign m_tdata   = {7'd0, hit, read_data};

  sacl_ctrl u_ctrl (
    .clk(clk), .rst(rst), .s_tvalid(s_tvalid), .s_tready(s_tready),
    .st(st), .cmd(cmd)
  );

  sacl_dp u_dp (
    .clk(clk), .rst(rst),
    .cfg_valid(cfg_valid), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .in_op(s_tdata[1:0]), .in_address(s_tdata[13:2]),
    .in_write_data(s_tdata[21:14]),
    .cmd(cmd), .st(st),
    .out_valid(m_tvalid), .out_ready(m_tready),
    .out_read_data(read_data), .out_hit(hit)
  );

endmodule

// ----- rtl/sacl_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module sacl_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ----- rtl/sacl_ctrl.sv -----
// Controller state machine of the set-associative LFU cache.
// Depends on sacl_pkg; drives commands into sacl_dp.
module sacl_ctrl
  import sacl_pkg::*;
(
  input  logic    clk,
  input  logic    rst,
  input  logic    s_tvalid,
  output logic    s_tready,
  input  status_t st,
  output cmd_t    cmd
);

  state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd        = '0;
    s_tready   = 1'b0;
    unique case (state)
      ST_IDLE: begin
        s_tready = 1'b1;
        if (s_tvalid) begin
          cmd.accept = 1'b1;
          state_next = ST_DISPATCH;
        end
      end
      ST_DISPATCH: begin
        if (st.op == OP_READ || st.op == OP_WRITE) begin
          state_next = ST_SCAN_RD;
        end else begin
          state_next = ST_DONE;
        end
      end
      ST_SCAN_RD: state_next = ST_SCAN_CHK;
      ST_SCAN_CHK: begin
        cmd.scan_chk = 1'b1;
        priority if (st.tag_match) begin
          state_next = ST_HIT;
        end else if (st.last_way) begin
          state_next = ST_FILL;
        end else begin
          state_next = ST_SCAN_RD;
        end
      end
      ST_HIT: begin
        cmd.hit_upd = 1'b1;
        state_next  = (st.op == OP_READ) ? ST_RD_WAIT : ST_DONE;
      end
      ST_FILL: begin
        cmd.fill_step = 1'b1;
        if (st.fill_done) begin
          state_next = ST_META_FILL;
        end
      end
      ST_META_FILL: begin
        cmd.meta_fill = 1'b1;
        state_next    = ST_FINAL;
      end
      ST_FINAL: begin
        cmd.final_acc = 1'b1;
        state_next    = (st.op == OP_READ) ? ST_RD_WAIT : ST_DONE;
      end
      ST_RD_WAIT: begin
        cmd.capture = 1'b1;
        state_next  = ST_DONE;
      end
      ST_DONE: begin
        if (st.out_free) begin
          cmd.load_out = 1'b1;
          state_next   = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  a_fill_then_meta: assert property (@(posedge clk) disable iff (rst)
    (state == ST_FILL && st.fill_done) |=> state == ST_META_FILL)
    else $error("fill did not end in the tag update");
  a_match_hits: assert property (@(posedge clk) disable iff (rst)
    (state == ST_SCAN_CHK && st.tag_match) |=> state == ST_HIT)
    else $error("tag match did not lead to the hit update");
  a_load_free: assert property (@(posedge clk) disable iff (rst)
    cmd.load_out |-> st.out_free)
    else $error("result loaded over a pending result");

endmodule

// ----- rtl/sacl_dp.sv -----
// Datapath of the set-associative LFU cache: config registers, line state,
// tag/frequency RAM, line byte RAM, backing RAM and the result register.
// Depends on sacl_pkg and sacl_ram; driven by sacl_ctrl.
module sacl_dp
  import sacl_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 cfg_valid,
  input  logic [IDX_BITS-1:0]  cfg_index,
  input  logic [CFG_BITS-1:0]  cfg_data,
  input  logic [1:0]           in_op,
  input  logic [ADDR_BITS-1:0] in_address,
  input  logic [7:0]           in_write_data,
  input  cmd_t                 cmd,
  output status_t              st,
  output logic                 out_valid,
  input  logic                 out_ready,
  output logic [7:0]           out_read_data,
  output logic                 out_hit
);

  logic [CFG_BITS-1:0] set_index_bits, offset_bits, ways_in_use;
  logic [CFG_BITS-1:0] sbits_e, obits_e, ways_e;
  logic [CFG_BITS-1:0] obits_r, ways_r;

  op_t                        op_r;
  logic [ADDR_BITS-1:0]       addr_r, tag_in, tag_r;
  logic [7:0]                 data_r, rd_byte;
  logic [MAX_SET_BITS-1:0]    set_in, set_r;
  logic [MAX_OFFSET_BITS-1:0] off_mask_in, off_mask_r, off_r;
  logic [CFG_BITS-1:0]        way_cnt;
  logic [CNT_BITS-1:0]        k;
  logic                       hit_r, inv_found;
  logic [WAY_BITS-1:0]        hit_way, inv_way, best_way, victim_way, line_way;
  logic [FREQ_BITS-1:0]       hit_freq, best_freq, freq_bump;
  logic [NUM_LINES-1:0]       line_valid;

  logic                       meta_we;
  logic [LINE_BITS-1:0]       meta_waddr, meta_raddr;
  logic [META_BITS-1:0]       meta_wdata, meta_rdata;
  logic [ADDR_BITS-1:0]       meta_tag;
  logic [FREQ_BITS-1:0]       meta_freq;
  logic                       cur_valid;

  logic                       bytes_we;
  logic [BYTE_BITS-1:0]       bytes_waddr, bytes_raddr;
  logic [7:0]                 bytes_wdata, bytes_rdata;

  logic                       back_we;
  logic [ADDR_BITS-1:0]       back_waddr, back_raddr, fill_base;
  logic [7:0]                 back_wdata, back_rdata;
  logic [MAX_OFFSET_BITS-1:0] k_prev;

  always_ff @(posedge clk) begin
    if (rst) begin
      set_index_bits <= CFG_BITS'(2);
      offset_bits    <= CFG_BITS'(2);
      ways_in_use    <= CFG_BITS'(2);
    end else if (cfg_valid) begin
      unique case (reg_idx_t'(cfg_index))
        REG_SET_BITS:    set_index_bits <= cfg_data;
        REG_OFFSET_BITS: offset_bits    <= cfg_data;
        REG_WAYS:        ways_in_use    <= cfg_data;
        default: ;
      endcase
    end
  end

  always_comb begin
    sbits_e = (set_index_bits > CFG_BITS'(MAX_SET_BITS)) ?
              CFG_BITS'(MAX_SET_BITS) : set_index_bits;
    obits_e = (offset_bits > CFG_BITS'(MAX_OFFSET_BITS)) ?
              CFG_BITS'(MAX_OFFSET_BITS) : offset_bits;
    if (ways_in_use == '0) begin
      ways_e = CFG_BITS'(1);
    end else if (ways_in_use > CFG_BITS'(MAX_WAYS)) begin
      ways_e = CFG_BITS'(MAX_WAYS);
    end else begin
      ways_e = ways_in_use;
    end
    tag_in      = in_address >> ({1'b0, sbits_e} + {1'b0, obits_e});
    set_in      = MAX_SET_BITS'(in_address >> obits_e) &
                  ~({MAX_SET_BITS{1'b1}} << sbits_e);
    off_mask_in = ~({MAX_OFFSET_BITS{1'b1}} << obits_e);
  end

  assign meta_raddr = {set_r, way_cnt[WAY_BITS-1:0]};
  assign meta_tag   = meta_rdata[META_BITS-1:FREQ_BITS];
  assign meta_freq  = meta_rdata[FREQ_BITS-1:0];
  assign cur_valid  = line_valid[meta_raddr];
  assign victim_way = inv_found ? inv_way : best_way;
  assign line_way   = hit_r ? hit_way : victim_way;
  assign freq_bump  = (hit_freq == '1) ? hit_freq : hit_freq + FREQ_BITS'(1);
  assign fill_base  = addr_r & ~ADDR_BITS'(off_mask_r);
  assign k_prev     = MAX_OFFSET_BITS'(k - CNT_BITS'(1));

  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      op_r       <= op_t'(in_op);
      addr_r     <= in_address;
      data_r     <= in_write_data;
      tag_r      <= tag_in;
      set_r      <= set_in;
      off_mask_r <= off_mask_in;
      off_r      <= in_address[MAX_OFFSET_BITS-1:0] & off_mask_in;
      obits_r    <= obits_e;
      ways_r     <= ways_e;
      way_cnt    <= '0;
      k          <= '0;
      hit_r      <= 1'b0;
      inv_found  <= 1'b0;
      rd_byte    <= '0;
    end
    if (cmd.scan_chk) begin
      way_cnt <= way_cnt + CFG_BITS'(1);
      if (cur_valid && meta_tag == tag_r) begin
        hit_r    <= 1'b1;
        hit_way  <= way_cnt[WAY_BITS-1:0];
        hit_freq <= meta_freq;
      end
      if (!cur_valid && !inv_found) begin
        inv_found <= 1'b1;
        inv_way   <= way_cnt[WAY_BITS-1:0];
      end
      if (way_cnt == '0 || meta_freq < best_freq) begin
        best_way  <= way_cnt[WAY_BITS-1:0];
        best_freq <= meta_freq;
      end
    end
    if (cmd.fill_step) begin
      k <= k + CNT_BITS'(1);
    end
    if (cmd.capture) begin
      rd_byte <= bytes_rdata;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      line_valid <= '0;
    end else if (cmd.meta_fill) begin
      line_valid[{set_r, victim_way}] <= 1'b1;
    end
  end

  always_comb begin
    meta_we    = cmd.hit_upd || cmd.meta_fill;
    meta_waddr = {set_r, line_way};
    meta_wdata = cmd.hit_upd ? {tag_r, freq_bump} : {tag_r, FREQ_BITS'(1)};

    bytes_raddr = {set_r, line_way, off_r};
    bytes_we    = 1'b0;
    bytes_waddr = {set_r, line_way, off_r};
    bytes_wdata = data_r;
    if ((cmd.hit_upd || cmd.final_acc) && op_r == OP_WRITE) begin
      bytes_we = 1'b1;
    end else if (cmd.fill_step && k != '0) begin
      bytes_we    = 1'b1;
      bytes_waddr = {set_r, victim_way, k_prev};
      bytes_wdata = back_rdata;
    end

    back_raddr = fill_base | ADDR_BITS'(k[MAX_OFFSET_BITS-1:0]);
    back_we    = 1'b0;
    back_waddr = addr_r;
    back_wdata = data_r;
    if (cmd.accept && op_t'(in_op) == OP_PRELOAD) begin
      back_we    = 1'b1;
      back_waddr = in_address;
      back_wdata = in_write_data;
    end else if (cmd.hit_upd && op_r == OP_WRITE) begin
      back_we = 1'b1;
    end
  end

  sacl_ram #(.WIDTH(META_BITS), .DEPTH(NUM_LINES)) u_meta (
    .clk(clk), .we(meta_we), .waddr(meta_waddr), .wdata(meta_wdata),
    .raddr(meta_raddr), .rdata(meta_rdata)
  );

  sacl_ram #(.WIDTH(8), .DEPTH(NUM_BYTES)) u_bytes (
    .clk(clk), .we(bytes_we), .waddr(bytes_waddr), .wdata(bytes_wdata),
    .raddr(bytes_raddr), .rdata(bytes_rdata)
  );

  sacl_ram #(.WIDTH(8), .DEPTH(MEM_SIZE)) u_back (
    .clk(clk), .we(back_we), .waddr(back_waddr), .wdata(back_wdata),
    .raddr(back_raddr), .rdata(back_rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.load_out) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      out_read_data <= (op_r == OP_READ) ? rd_byte : 8'd0;
      out_hit       <= hit_r;
    end
  end

  always_comb begin
    st.op        = op_r;
    st.tag_match = cur_valid && meta_tag == tag_r;
    st.last_way  = (way_cnt + CFG_BITS'(1)) == ways_r;
    st.fill_done = k == (CNT_BITS'(1) << obits_r);
    st.out_free  = !out_valid || out_ready;
  end

endmodule

// ----- tb/tb_top.sv -----
// Testbench for the set-associative LFU cache: random and directed items with
// a self-checking scoreboard that predicts every result. Depends on sacl_pkg
// and the set_assoc_cache_lfu RTL.
module tb_top;
  import sacl_pkg::*;

  typedef struct packed {
    logic [7:0] read_data;
    logic       hit;
  } cache_result_t;

  class cache_scoreboard;
    bit [2:0]     set_bits_reg;
    bit [2:0]     offset_bits_reg;
    bit [2:0]     ways_reg;
    bit           valid_line[NUM_LINES];
    bit [7:0]     freq[NUM_LINES];
    bit [11:0]    line_tag[NUM_LINES];
    bit [7:0]     line_data[NUM_BYTES];
    bit           line_known[NUM_BYTES];
    bit [7:0]     mem[MEM_SIZE];
    bit           mem_known[MEM_SIZE];
    cache_result_t pending_results[$];
    int unsigned  errors;

    function new();
      set_bits_reg = 3'd2;
      offset_bits_reg = 3'd2;
      ways_reg = 3'd2;
      errors = 0;
    endfunction

    function void write_reg(reg_idx_t idx, bit [2:0] val);
      case (idx)
        REG_SET_BITS:    set_bits_reg = val;
        REG_OFFSET_BITS: offset_bits_reg = val;
        REG_WAYS:        ways_reg = val;
        default: ;
      endcase
    endfunction

    function int unsigned sbits();
      return (set_bits_reg > MAX_SET_BITS) ? MAX_SET_BITS : set_bits_reg;
    endfunction

    function int unsigned obits();
      return (offset_bits_reg > MAX_OFFSET_BITS) ? MAX_OFFSET_BITS : offset_bits_reg;
    endfunction

    function int unsigned ways();
      if (ways_reg == 0) return 1;
      return (ways_reg > MAX_WAYS) ? MAX_WAYS : ways_reg;
    endfunction

    function void lookup(input bit [11:0] addr, output int unsigned set_i,
                         output bit [11:0] tag_v, output int unsigned off,
                         output int unsigned ln, output bit found);
      set_i = (addr >> obits()) & ((1 << sbits()) - 1);
      tag_v = addr >> (sbits() + obits());
      off = addr & ((1 << obits()) - 1);
      found = 0;
      ln = 0;
      for (int w = 0; w < ways(); w++) begin
        if (!found && valid_line[set_i*MAX_WAYS+w] && line_tag[set_i*MAX_WAYS+w] == tag_v) begin
          ln = set_i*MAX_WAYS + w;
          found = 1;
        end
      end
    endfunction

    // A read hit must not touch a cached byte never written, and a miss
    // must not fetch a backing byte never written.
    function bit hit_byte_unknown(op_t op, bit [11:0] addr);
      int unsigned set_i, off, ln;
      bit [11:0] tag_v;
      bit found;
      lookup(addr, set_i, tag_v, off, ln, found);
      return found && op == OP_READ && !line_known[ln*16+off];
    endfunction

    function bit miss_block_known(op_t op, bit [11:0] addr);
      int unsigned set_i, off, ln, base;
      bit [11:0] tag_v;
      bit found;
      lookup(addr, set_i, tag_v, off, ln, found);
      if (found || op == OP_PRELOAD || op == OP_NONE) return 1;
      base = addr & ~((1 << obits()) - 1);
      for (int k = 0; k < (1 << obits()); k++)
        if (!mem_known[(base+k) & 12'hFFF]) return 0;
      return 1;
    endfunction

    function void note_item(op_t op, bit [11:0] addr, bit [7:0] wdata);
      cache_result_t r;
      int unsigned set_i, off, ln, base;
      bit [11:0] tag_v;
      bit found, empty;
      r = '0;
      if (op == OP_PRELOAD) begin
        mem[addr] = wdata;
        mem_known[addr] = 1;
      end else if (op != OP_NONE) begin
        lookup(addr, set_i, tag_v, off, ln, found);
        if (found) begin
          if (freq[ln] != 8'hFF) freq[ln]++;
          r.hit = 1;
          if (op == OP_READ) r.read_data = line_data[ln*16+off];
          else begin
            line_data[ln*16+off] = wdata;
            line_known[ln*16+off] = 1;
            mem[addr] = wdata;
            mem_known[addr] = 1;
          end
        end else begin
          empty = 0;
          for (int w = 0; w < ways(); w++) begin
            if (!empty && !valid_line[set_i*MAX_WAYS+w]) begin
              ln = set_i*MAX_WAYS + w;
              empty = 1;
            end
          end
          if (!empty) begin
            ln = set_i*MAX_WAYS;
            for (int w = 1; w < ways(); w++)
              if (freq[set_i*MAX_WAYS+w] < freq[ln]) ln = set_i*MAX_WAYS + w;
            freq[ln] = 8'd1;
          end
          base = addr & ~((1 << obits()) - 1);
          for (int k = 0; k < (1 << obits()); k++) begin
            line_data[ln*16+k] = mem[(base+k) & 12'hFFF];
            line_known[ln*16+k] = 1;
          end
          line_tag[ln] = tag_v;
          valid_line[ln] = 1;
          if (empty && freq[ln] != 8'hFF) freq[ln]++;
          if (op == OP_READ) r.read_data = line_data[ln*16+off];
          else line_data[ln*16+off] = wdata;
        end
      end
      pending_results.push_back(r);
    endfunction

    function void check_result(logic [15:0] tdata);
      cache_result_t exp_r;
      if (pending_results.size() == 0) begin
        errors++;
        if (errors <= 10) $display("unexpected result item: %h", tdata);
        return;
      end
      exp_r = pending_results.pop_front();
      if (tdata[7:0] !== exp_r.read_data || tdata[8] !== exp_r.hit) begin
        errors++;
        if (errors <= 10)
          $display("mismatch: expected read_data %h hit %b, got read_data %h hit %b",
                   exp_r.read_data, exp_r.hit, tdata[7:0], tdata[8]);
      end
    endfunction
  endclass

  logic                clk = 0;
  logic                rst;
  logic                s_tvalid;
  logic                s_tready;
  logic [23:0]         s_tdata;   // op[1:0], address[13:2], write_data[21:14]
  logic                m_tvalid;
  logic                m_tready;
  logic [15:0]         m_tdata;   // read_data[7:0], hit[8]
  logic                cfg_valid;
  logic                cfg_ready;
  logic [IDX_BITS-1:0] cfg_index;
  logic [CFG_BITS-1:0] cfg_data;

  cache_scoreboard sb = new();
  int unsigned     send_idle_pct = 0;
  int unsigned     recv_stall_pct = 0;
  bit [5:0]        hot_tags[4];

  set_assoc_cache_lfu i_dut (.*);

  always #6 clk = ~clk;

  always @(posedge clk) begin
    if (rst) begin
      m_tready <= 1'b0;
    end else begin
      if (m_tvalid && m_tready) sb.check_result(m_tdata);
      m_tready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  task automatic send_raw(op_t op, bit [11:0] addr, bit [7:0] wdata);
    s_tvalid <= 1'b1;
    s_tdata <= {2'b00, wdata, addr, op};
    do @(posedge clk); while (!s_tready);
    sb.note_item(op, addr, wdata);
    if ($urandom_range(99) < send_idle_pct) begin
      s_tvalid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < send_idle_pct);
    end
  endtask

  task automatic issue(op_t op, bit [11:0] addr, bit [7:0] wdata);
    bit [11:0] base;
    if (sb.hit_byte_unknown(op, addr)) op = OP_WRITE;
    if (!sb.miss_block_known(op, addr)) begin
      base = 12'(addr & ~((1 << sb.obits()) - 1));
      for (int k = 0; k < (1 << sb.obits()); k++)
        if (!sb.mem_known[(base+k) & 12'hFFF])
          send_raw(OP_PRELOAD, 12'(base + k), 8'($urandom));
    end
    send_raw(op, addr, wdata);
  endtask

  task automatic drain();
    s_tvalid <= 1'b0;
    do @(posedge clk); while (sb.pending_results.size() != 0);
    repeat (10) @(posedge clk);
  endtask

  task automatic set_reg(reg_idx_t idx, bit [2:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    do @(posedge clk); while (!cfg_ready);
    sb.write_reg(idx, val);
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  task automatic random_items(int n);
    op_t       op;
    bit [11:0] addr;
    int unsigned r;
    for (int i = 0; i < n; i++) begin
      r = $urandom_range(99);
      op = (r < 45) ? OP_READ : (r < 75) ? OP_WRITE : (r < 95) ? OP_PRELOAD : OP_NONE;
      if ($urandom_range(99) < 95) addr = {hot_tags[$urandom_range(3)], 6'($urandom)};
      else addr = 12'($urandom);
      issue(op, addr, 8'($urandom));
      if (i == n / 2 && n > 50) begin
        s_tvalid <= 1'b0;
        do @(posedge clk); while (sb.pending_results.size() != 0);
      end
    end
  endtask

  initial begin
    static bit [2:0] cfgs[5][3] = '{'{3'd2, 3'd2, 3'd2}, '{3'd0, 3'd0, 3'd1},
                                    '{3'd4, 3'd4, 3'd4}, '{3'd7, 3'd7, 3'd0},
                                    '{3'd3, 3'd1, 3'd3}};
    static int unsigned idle_sets[4][2] = '{'{0, 0}, '{76, 0}, '{0, 76}, '{36, 36}};
    bit [11:0] hammer_addr;
    rst <= 1'b1;
    s_tvalid <= 1'b0;
    s_tdata <= '0;
    cfg_valid <= 1'b0;
    cfg_index <= REG_SET_BITS;
    cfg_data <= '0;
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    issue(OP_PRELOAD, 12'h000, 8'h00);
    issue(OP_PRELOAD, 12'hFFF, 8'hFF);
    issue(OP_READ, 12'h000, 8'h00);
    issue(OP_READ, 12'h001, 8'h00);
    issue(OP_WRITE, 12'h002, 8'hA5);
    issue(OP_READ, 12'h002, 8'h00);
    issue(OP_WRITE, 12'hFFF, 8'h5A);
    issue(OP_READ, 12'hFFF, 8'h00);
    issue(OP_PRELOAD, 12'h000, 8'h77);
    issue(OP_READ, 12'h000, 8'h00);
    issue(OP_NONE, 12'hFFF, 8'hFF);
    issue(OP_READ, 12'h100, 8'h00);
    issue(OP_READ, 12'h200, 8'h00);
    issue(OP_WRITE, 12'h300, 8'h3C);
    issue(OP_READ, 12'h300, 8'h00);
    issue(OP_READ, 12'h000, 8'h00);
    drain();
    set_reg(REG_UNUSED, 3'd5);

    foreach (hot_tags[k]) hot_tags[k] = 6'($urandom);
    for (int c = 0; c < 5; c++) begin
      set_reg(REG_SET_BITS, cfgs[c][0]);
      set_reg(REG_OFFSET_BITS, cfgs[c][1]);
      set_reg(REG_WAYS, cfgs[c][2]);
      for (int p = 0; p < 4; p++) begin
        send_idle_pct = idle_sets[p][0];
        recv_stall_pct = idle_sets[p][1];
        random_items(70);
      end
      if (c == 2) begin
        send_idle_pct = 0;
        recv_stall_pct = 0;
        hammer_addr = 12'($urandom);
        for (int i = 0; i < 300; i++) issue(OP_READ, hammer_addr, 8'h00);
        random_items(50);
      end
      drain();
    end

    drain();
    repeat (50) @(posedge clk);
    if (sb.errors == 0 && sb.pending_results.size() == 0) begin
      $display("[set_assoc_cache_lfu] OK");
    end else begin
      $display("[set_assoc_cache_lfu] ERROR");
    end
    $finish;
  end

  initial begin
    #(12 * 4000000);
    $display("[set_assoc_cache_lfu] ERROR");
    $finish;
  end

endmodule

// ----- set_assoc_cache_lfu.f -----
rtl/sacl_pkg.sv
rtl/sacl_ram.sv
rtl/sacl_ctrl.sv
rtl/sacl_dp.sv
rtl/set_assoc_cache_lfu.sv
tb/tb_top.sv
